// ===== rtl/core/aeit_pkg.sv =====
// ============================================================================
// aeit_pkg
// Shared types and constants for the archive extent index table.
// ============================================================================
package aeit_pkg;

    // Widest entry index the block supports (ENTRIES up to 4096)
    localparam int ADDR_MAX_W  = 12;
    // At most this many results for one overlap scan
    localparam int MAX_RESULTS = 64;
    localparam int HITS_W      = $clog2(MAX_RESULTS + 1);
    // Group word flag bits
    localparam int BIT_SECOND  = 24;
    localparam int BIT_RAW     = 17;

    typedef enum logic [2:0] {
        CMD_BEGIN_LOAD  = 3'd0,
        CMD_WRITE_ENTRY = 3'd1,
        CMD_EXACT_FIND  = 3'd2,
        CMD_OVERLAP     = 3'd3,
        CMD_READ_INDEX  = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_MISS       = 3'd1,
        STATUS_NOT_LOADED = 3'd2,
        STATUS_REJECTED   = 3'd3,
        STATUS_NO_LOAD    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RDIDX,
        S_FLUSH
    } state_t;

    // One stored extent
    typedef struct packed {
        logic [31:0] grp;
        logic [31:0] off;
        logic [31:0] csz;
        logic [31:0] dsz;
    } entry_t;

    // One input transaction, unpacked from the stream ports
    typedef struct packed {
        logic [2:0]            cmd;
        logic                  sel;
        logic [31:0]           count;
        logic [31:0]           grp;
        logic [31:0]           off;
        logic [31:0]           csz;
        logic [31:0]           dsz;
        logic [31:0]           rend;
        logic [ADDR_MAX_W-1:0] index;
    } in_item_t;

    // Search key held for the length of a scan
    typedef struct packed {
        logic        find;
        logic        sel;
        logic [31:0] off;
        logic [31:0] csz;
        logic [31:0] rend;
    } key_t;

    // One result transaction
    typedef struct packed {
        status_t               status;
        logic [ADDR_MAX_W-1:0] idx;
        entry_t                entry;
    } result_t;

    // Request to the two entry memories
    typedef struct packed {
        logic                  we;
        logic [ADDR_MAX_W-1:0] waddr;
        entry_t                wentry;
        logic                  re;
        logic [ADDR_MAX_W-1:0] raddr;
    } mem_req_t;

endpackage

// ===== rtl/core/aeit_ram.sv =====
// ============================================================================
// aeit_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read data holds while no read is issued.
// ============================================================================
module aeit_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 64,
    parameter int AW     = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/aeit_match.sv =====
// ============================================================================
// aeit_match
// Compares one stored entry against the search key (exact or overlap).
// ============================================================================
module aeit_match import aeit_pkg::*; (
    input  key_t   key,
    input  entry_t entry,
    output logic   hit
);

    logic        base_ok;
    logic        exact_ok;
    logic        overlap_ok;
    logic [31:0] entry_end;

    // Archive and nonzero size qualify every search
    assign base_ok    = (entry.csz != 32'd0) && (entry.grp[BIT_SECOND] == key.sel);
    assign exact_ok   = (entry.off == key.off) && (entry.csz == key.csz);
    // End wraps modulo 2^32
    assign entry_end  = entry.off + entry.csz;
    assign overlap_ok = (entry.off < key.rend) && (key.off < entry_end);

    assign hit = base_ok && (key.find ? exact_ok : overlap_ok);

endmodule

// ===== rtl/core/aeit_ctrl.sv =====
// ============================================================================
// aeit_ctrl
// Command sequencer: load bookkeeping, memory scan, result hold and output
// register.
// ============================================================================
module aeit_ctrl import aeit_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    output mem_req_t mem_req,
    input  entry_t   rd_entry,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_result,
    output logic     out_last
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   entry_total_reg, entry_total_next;
    logic [CNT_W-1:0]   write_cursor_reg, write_cursor_next;
    logic               table_loaded_reg, table_loaded_next;
    logic               load_pending_reg, load_pending_next;
    key_t               key_reg, key_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [HITS_W-1:0]  hits_reg, hits_next;
    result_t            pend_reg, pend_next;
    logic               pend_hit_reg, pend_hit_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;
    logic               out_last_reg, out_last_next;

    logic               accept;
    logic               can_emit;
    logic               match_hit;
    logic               scan_hit;
    logic               need_flush_old;
    logic               consume;
    logic               stop;
    logic               more;
    logic               advance;
    logic               scan_done;
    logic               index_ok;
    logic               empty_range;

    aeit_match u_match (
        .key   (key_reg),
        .entry (rd_entry),
        .hit   (match_hit)
    );

    // Handshake and scan pipeline control
    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign can_emit       = !out_valid_reg || out_ready;
    assign scan_hit       = rd_valid_reg && match_hit;
    assign need_flush_old = scan_hit && !key_reg.find && pend_hit_reg;
    assign consume        = rd_valid_reg && (!need_flush_old || can_emit);
    assign stop           = consume && scan_hit &&
                            (key_reg.find || (hits_reg == HITS_W'(MAX_RESULTS - 1)));
    assign more           = (issue_reg < entry_total_reg);
    assign advance        = (state_reg == S_SCAN) && more &&
                            (!rd_valid_reg || consume) && !stop;
    assign scan_done      = (!rd_valid_reg && !more) || stop;
    assign index_ok       = ({1'b0, in_item.index} < (ADDR_MAX_W + 1)'(entry_total_reg));
    assign empty_range    = (in_item.rend <= in_item.off);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_t'(in_item.cmd))
                        CMD_BEGIN_LOAD,
                        CMD_WRITE_ENTRY: state_next = S_FLUSH;
                        CMD_EXACT_FIND:  state_next = table_loaded_reg ? S_SCAN : S_FLUSH;
                        CMD_OVERLAP:
                            state_next = (empty_range || !table_loaded_reg) ? S_FLUSH : S_SCAN;
                        CMD_READ_INDEX:
                            state_next = (table_loaded_reg && index_ok) ? S_RDIDX : S_FLUSH;
                        default:         state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_RDIDX: state_next = S_FLUSH;
            S_FLUSH:
            begin
                if (can_emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb
    begin
        entry_total_next  = entry_total_reg;
        write_cursor_next = write_cursor_reg;
        table_loaded_next = table_loaded_reg;
        load_pending_next = load_pending_reg;
        key_next          = key_reg;
        issue_next        = issue_reg;
        rd_valid_next     = rd_valid_reg;
        rd_idx_next       = rd_idx_reg;
        hits_next         = hits_reg;
        pend_next         = pend_reg;
        pend_hit_next     = pend_hit_reg;
        out_next          = out_reg;
        out_last_next     = out_last_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mem_req           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next.find = (cmd_t'(in_item.cmd) == CMD_EXACT_FIND);
                    key_next.sel  = in_item.sel;
                    key_next.off  = in_item.off;
                    key_next.csz  = in_item.csz;
                    key_next.rend = in_item.rend;
                    issue_next    = '0;
                    rd_valid_next = 1'b0;
                    rd_idx_next   = in_item.index[AW-1:0];
                    hits_next     = '0;
                    pend_hit_next = 1'b0;
                    pend_next     = '0;
                    unique case (cmd_t'(in_item.cmd))
                        CMD_BEGIN_LOAD:
                        begin
                            if (in_item.count > 32'(ENTRIES))
                            begin
                                pend_next.status = STATUS_REJECTED;
                            end
                            else
                            begin
                                entry_total_next  = in_item.count[CNT_W-1:0];
                                write_cursor_next = '0;
                                table_loaded_next = (in_item.count == 32'd0);
                                load_pending_next = (in_item.count != 32'd0);
                            end
                        end
                        CMD_WRITE_ENTRY:
                        begin
                            if (!load_pending_reg || !(write_cursor_reg < entry_total_reg))
                            begin
                                pend_next.status = STATUS_NO_LOAD;
                            end
                            else
                            begin
                                mem_req.we         = 1'b1;
                                mem_req.waddr      = ADDR_MAX_W'(write_cursor_reg[AW-1:0]);
                                mem_req.wentry.grp = in_item.grp;
                                mem_req.wentry.off = in_item.off;
                                mem_req.wentry.csz = in_item.csz;
                                mem_req.wentry.dsz = in_item.dsz;
                                write_cursor_next  = write_cursor_reg + CNT_W'(1);
                                if (write_cursor_next == entry_total_reg)
                                begin
                                    table_loaded_next = 1'b1;
                                    load_pending_next = 1'b0;
                                end
                                pend_next.idx   = ADDR_MAX_W'(write_cursor_reg[AW-1:0]);
                                pend_next.entry = mem_req.wentry;
                            end
                        end
                        CMD_EXACT_FIND:
                        begin
                            pend_next.status = table_loaded_reg ? STATUS_MISS
                                                                : STATUS_NOT_LOADED;
                        end
                        CMD_OVERLAP:
                        begin
                            if (empty_range || table_loaded_reg)
                            begin
                                pend_next.status = STATUS_MISS;
                            end
                            else
                            begin
                                pend_next.status = STATUS_NOT_LOADED;
                            end
                        end
                        CMD_READ_INDEX:
                        begin
                            if (!table_loaded_reg)
                            begin
                                pend_next.status = STATUS_NOT_LOADED;
                            end
                            else if (!index_ok)
                            begin
                                pend_next.status = STATUS_MISS;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ADDR_MAX_W'(in_item.index[AW-1:0]);
                            end
                        end
                        default:
                        begin
                            pend_next = pend_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // One read issued per cycle while the scan is not stalled; read data holds while stalled
                mem_req.re    = advance;
                mem_req.raddr = ADDR_MAX_W'(issue_reg[AW-1:0]);
                if (advance)
                begin
                    issue_next    = issue_reg + CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_idx_next   = issue_reg[AW-1:0];
                end
                else if (consume)
                begin
                    rd_valid_next = 1'b0;
                end
                // A new hit pushes the held one out; the newest stays held
                // so that the final one can carry last
                if (consume && scan_hit)
                begin
                    if (need_flush_old)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b0;
                    end
                    pend_next.status = STATUS_OK;
                    pend_next.idx    = ADDR_MAX_W'(rd_idx_reg);
                    pend_next.entry  = rd_entry;
                    pend_hit_next    = 1'b1;
                    hits_next        = hits_reg + HITS_W'(1);
                end
            end
            S_RDIDX:
            begin
                pend_next.status = STATUS_OK;
                pend_next.idx    = ADDR_MAX_W'(rd_idx_reg);
                pend_next.entry  = rd_entry;
            end
            S_FLUSH:
            begin
                if (can_emit)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_last_next  = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            entry_total_reg  <= '0;
            write_cursor_reg <= '0;
            table_loaded_reg <= 1'b0;
            load_pending_reg <= 1'b0;
            issue_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            hits_reg         <= '0;
            pend_hit_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entry_total_reg  <= entry_total_next;
            write_cursor_reg <= write_cursor_next;
            table_loaded_reg <= table_loaded_next;
            load_pending_reg <= load_pending_next;
            issue_reg        <= issue_next;
            rd_valid_reg     <= rd_valid_next;
            hits_reg         <= hits_next;
            pend_hit_reg     <= pend_hit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        rd_idx_reg   <= rd_idx_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== rtl/core/archive_extent_index_table_top.sv =====
// ============================================================================
// archive_extent_index_table_top
// Index of archive extents with load, exact find, overlap scan and read.
// ============================================================================
// Input transactions arrive on the s_ stream: s_tuser carries the command and
// the archive select, s_tdata the count, entry words and query fields. Each
// accepted command (codes five to seven excepted) gives one or more result
// transactions on the m_ stream; m_tuser carries the status and m_tlast marks
// the final result of a command.
// Begin load and write entry go from accept through the flush state to the
// output register; read by index passes through the S_RDIDX state first. Exact
// find and overlap scan read the entry memories through their single read
// port, one entry per cycle unless a result stall holds the scan; an exact
// find stops at its first hit. Commands are handled one at a time: s_tready
// is high only while the block is idle.
// Reset empties the index (no entries, not loaded, no load pending); the
// entry memories are not cleared and are only read after a load rewrites them.
// When the receiver stalls, the result register holds and a scan pauses on
// its next hit until the result is taken.
module archive_extent_index_table_top import aeit_pkg::*; #(
    parameter int ENTRIES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // count[31:0], group_word[63:32], offset[95:64], comp_size[127:96],
    // decomp_size[159:128], query_end[191:160], read_index[203:192], zero pad
    input  logic [207:0] s_tdata,
    // cmd[2:0], archive_sel[3]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_index[11:0], hit_group[43:12], hit_offset[75:44],
    // hit_comp_size[107:76], hit_decomp_size[139:108],
    // hit_second_archive[140], hit_raw[141], zero pad
    output logic [143:0] m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    in_item_t in_item;
    mem_req_t mem_req;
    entry_t   rd_entry;
    result_t  out_result;
    logic     out_last;
    logic     out_valid;

    // Unpack the input transaction
    assign in_item.cmd   = s_tuser[2:0];
    assign in_item.sel   = s_tuser[3];
    assign in_item.count = s_tdata[31:0];
    assign in_item.grp   = s_tdata[63:32];
    assign in_item.off   = s_tdata[95:64];
    assign in_item.csz   = s_tdata[127:96];
    assign in_item.dsz   = s_tdata[159:128];
    assign in_item.rend  = s_tdata[191:160];
    assign in_item.index = s_tdata[203:192];

    aeit_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .mem_req    (mem_req),
        .rd_entry   (rd_entry),
        .out_valid  (out_valid),
        .out_ready  (m_tready),
        .out_result (out_result),
        .out_last   (out_last)
    );

    // Offset and compressed size
    aeit_ram #(
        .DATA_W (64),
        .DEPTH  (ENTRIES),
        .AW     (AW)
    ) u_place_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr[AW-1:0]),
        .wdata ({mem_req.wentry.off, mem_req.wentry.csz}),
        .re    (mem_req.re),
        .raddr (mem_req.raddr[AW-1:0]),
        .rdata ({rd_entry.off, rd_entry.csz})
    );

    // Group word and decompressed size
    aeit_ram #(
        .DATA_W (64),
        .DEPTH  (ENTRIES),
        .AW     (AW)
    ) u_group_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr[AW-1:0]),
        .wdata ({mem_req.wentry.grp, mem_req.wentry.dsz}),
        .re    (mem_req.re),
        .raddr (mem_req.raddr[AW-1:0]),
        .rdata ({rd_entry.grp, rd_entry.dsz})
    );

    // Pack the result transaction; flags come from the group word
    assign m_tvalid = out_valid;
    assign m_tlast  = out_last;
    assign m_tuser  = out_result.status;
    assign m_tdata  = {2'b00,
                       out_result.entry.grp[BIT_RAW],
                       out_result.entry.grp[BIT_SECOND],
                       out_result.entry.dsz,
                       out_result.entry.csz,
                       out_result.entry.off,
                       out_result.entry.grp,
                       out_result.idx};

`ifndef ASSERT_OFF
    // A command that produces results blocks further input until it is done
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser[2:0] <= CMD_READ_INDEX)) |=> !s_tready)
        else $error("input accepted while a command is in progress");

    // Any status other than ok ends the command's results
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STATUS_OK)) |-> m_tlast)
        else $error("non-ok result not marked last");

    // A result without an entry carries zero entry fields
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != STATUS_OK)) |-> (m_tdata == '0))
        else $error("non-ok result carries entry data");

    // Entries are written only by an accepted write transaction
    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.we |-> (s_tvalid && s_tready && (s_tuser[2:0] == CMD_WRITE_ENTRY)))
        else $error("entry memory written outside a write transaction");
`endif

endmodule
